// ----- rtl/lpsr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpsr_pkg
// Shared constants, microcode table, pixel map and control types for the
// LED panel shadow RAM controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsr_pkg;

  localparam int GRID_COUNT = 24;
  localparam int ENTRIES    = 2 * GRID_COUNT;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = IDX_W;
  localparam int LINE_COLS  = 17;

  // operations
  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_FLUSH = 3'd2;
  localparam logic [2:0] OP_ON    = 3'd3;
  localparam logic [2:0] OP_OFF   = 3'd4;

  // microcode steps
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_SET_RD  = 4'd2;
  localparam logic [3:0] ST_SET_WR  = 4'd3;
  localparam logic [3:0] ST_CLR     = 4'd4;
  localparam logic [3:0] ST_ON      = 4'd5;
  localparam logic [3:0] ST_OFF     = 4'd6;
  localparam logic [3:0] ST_FL_INIT = 4'd7;
  localparam logic [3:0] ST_FL_RD   = 4'd8;
  localparam logic [3:0] ST_FL_EM   = 4'd9;

  // jump conditions
  localparam logic [1:0] JC_ALWAYS   = 2'd0;
  localparam logic [1:0] JC_ACCEPT   = 2'd1;
  localparam logic [1:0] JC_DISPATCH = 2'd2;
  localparam logic [1:0] JC_CNT_MORE = 2'd3;

  // word sources
  localparam logic [2:0] EM_NONE   = 3'd0;
  localparam logic [2:0] EM_STATUS = 3'd1;
  localparam logic [2:0] EM_FRAME  = 3'd2;
  localparam logic [2:0] EM_ON     = 3'd3;
  localparam logic [2:0] EM_OFF    = 3'd4;

  // last-word select
  localparam logic [1:0] LS_NO  = 2'd0;
  localparam logic [1:0] LS_YES = 2'd1;
  localparam logic [1:0] LS_CNT = 2'd2;

  // counter ops
  localparam logic [1:0] CN_HOLD = 2'd0;
  localparam logic [1:0] CN_CLR  = 2'd1;
  localparam logic [1:0] CN_INC  = 2'd2;

  // RAM address select
  localparam logic AS_MAP = 1'b0;
  localparam logic AS_CNT = 1'b1;

  localparam logic [7:0] CMD_DISPLAY = 8'h48;
  localparam logic [7:0] CTRL_ON     = 8'h88;
  localparam logic [7:0] CTRL_OFF    = 8'h80;
  localparam logic [7:0] CMD_GRID    = 8'hC0;
  localparam logic [7:0] GRID_MASK   = 8'h1F;
  localparam logic [7:0] MAP_NONE    = 8'hFF;
  localparam logic [4:0] SPLIT_COL   = 5'd27;

  typedef struct packed {
    logic [1:0] cond;
    logic [3:0] target;
    logic [2:0] emit;
    logic [1:0] last;
    logic [1:0] cnt;
    logic       addr_sel;
    logic       ram_wr;
    logic       clr;
  } uword_t;

  typedef struct packed {
    logic             ld_in;
    logic [2:0]       emit;
    logic             last;
    logic             addr_sel;
    logic             ram_wr;
    logic             clr;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [2:0]       bit_pos;
  } loc_t;

  localparam logic [7:0] CELL_MAP [0:6][0:LINE_COLS-1] = '{
    '{8'hB6,8'h6B,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h67,8'h68,8'h69,8'h6A,
      8'h76,8'h86,8'h96,8'hA7,8'hA5},
    '{8'hB5,8'h5B,8'h50,8'h51,8'h52,8'h53,8'h54,8'h56,8'h57,8'h58,8'h59,8'h5A,
      8'h75,8'h85,8'h95,8'h97,8'hA6},
    '{8'hB4,8'h4B,8'h40,8'h41,8'h42,8'h43,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
      8'h74,8'h84,8'h94,8'hA9,8'hA8},
    '{8'hB3,8'h3B,8'h30,8'h31,8'h32,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3A,
      8'h73,8'h83,8'h93,8'h9A,8'h98},
    '{8'hB2,8'h2B,8'h20,8'h21,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,
      8'h72,8'h82,8'h92,8'h7A,8'h8A},
    '{8'hB1,8'h1B,8'h10,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
      8'h71,8'h81,8'h91,8'h89,8'h87},
    '{8'hB0,8'h0B,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,
      8'h70,8'h80,8'h90,8'h79,8'h78}
  };

  function automatic uword_t ucode(input logic [3:0] pc);
    uword_t w;
    w = '{JC_ALWAYS, ST_IDLE, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
    unique case (pc)
      ST_IDLE:    w = '{JC_ACCEPT, ST_DECODE, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
      ST_DECODE:  w = '{JC_DISPATCH, ST_IDLE, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
      ST_SET_RD:  w = '{JC_ALWAYS, ST_SET_WR, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
      ST_SET_WR:  w = '{JC_ALWAYS, ST_IDLE, EM_STATUS, LS_YES, CN_HOLD, AS_MAP, 1'b1, 1'b0};
      ST_CLR:     w = '{JC_ALWAYS, ST_IDLE, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b1};
      ST_ON:      w = '{JC_ALWAYS, ST_FL_INIT, EM_ON, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
      ST_OFF:     w = '{JC_ALWAYS, ST_IDLE, EM_OFF, LS_YES, CN_HOLD, AS_MAP, 1'b0, 1'b0};
      ST_FL_INIT: w = '{JC_ALWAYS, ST_FL_RD, EM_NONE, LS_NO, CN_CLR, AS_MAP, 1'b0, 1'b0};
      ST_FL_RD:   w = '{JC_ALWAYS, ST_FL_EM, EM_NONE, LS_NO, CN_HOLD, AS_CNT, 1'b0, 1'b0};
      ST_FL_EM:   w = '{JC_CNT_MORE, ST_FL_RD, EM_FRAME, LS_CNT, CN_INC, AS_CNT, 1'b0, 1'b0};
      default:    w = '{JC_ALWAYS, ST_IDLE, EM_NONE, LS_NO, CN_HOLD, AS_MAP, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] dispatch(input logic [2:0] op);
    logic [3:0] pc;
    unique case (op)
      OP_SET:   pc = ST_SET_RD;
      OP_CLEAR: pc = ST_CLR;
      OP_FLUSH: pc = ST_FL_INIT;
      OP_ON:    pc = ST_ON;
      OP_OFF:   pc = ST_OFF;
      default:  pc = ST_IDLE;
    endcase
    return pc;
  endfunction

  function automatic loc_t locate(input logic [4:0] x, input logic [2:0] y);
    loc_t       r;
    logic [7:0] e;
    logic       line;
    logic [4:0] grid;
    r    = '0;
    e    = MAP_NONE;
    line = 1'b0;
    grid = '0;
    if (x <= SPLIT_COL && y <= 3'd6) begin
      if (x == SPLIT_COL) begin
        line      = 1'b1;
        grid      = (y >= 3'd4) ? 5'd15 : 5'd14;
        r.bit_pos = 3'd6 - y;
        r.ok      = 1'b1;
      end else begin
        if (x < 5'(LINE_COLS)) begin
          e = CELL_MAP[y][x];
        end else begin
          line = 1'b1;
          e    = CELL_MAP[y][5'd28 - x];
        end
        grid      = e[7:3];
        r.bit_pos = e[2:0];
        r.ok      = (e != MAP_NONE);
      end
      if ({1'b0, grid} >= 6'(GRID_COUNT)) begin
        r.ok = 1'b0;
      end
      r.idx = line ? IDX_W'(GRID_COUNT) + IDX_W'(grid) : IDX_W'(grid);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lpsr_useq.sv -----
// ----------------------------------------------------------------------------
// lpsr_useq
// Microcode sequencer: step counter, control ROM, loop counter and jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsr_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [2:0]    op,
  input  wire logic          slot_free,
  output logic               in_ready,
  output lpsr_pkg::ctl_t     ctl
);

  localparam logic [lpsr_pkg::CNT_W-1:0] CNT_LAST = lpsr_pkg::CNT_W'(lpsr_pkg::ENTRIES - 1);

  logic [3:0]                 upc_r, upc_nxt;
  logic [lpsr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  lpsr_pkg::uword_t           uw;
  logic                       stall, go, accept, cnt_end;

  assign uw       = lpsr_pkg::ucode(upc_r);
  assign stall    = (uw.emit != lpsr_pkg::EM_NONE) && !slot_free;
  assign go       = !stall;
  assign in_ready = (upc_r == lpsr_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_end  = (cnt_r == CNT_LAST);

  always_comb begin
    upc_nxt = upc_r;
    if (go) begin
      unique case (uw.cond)
        lpsr_pkg::JC_ALWAYS:   upc_nxt = uw.target;
        lpsr_pkg::JC_ACCEPT:   upc_nxt = accept ? uw.target : upc_r;
        lpsr_pkg::JC_DISPATCH: upc_nxt = lpsr_pkg::dispatch(op);
        lpsr_pkg::JC_CNT_MORE: upc_nxt = cnt_end ? lpsr_pkg::ST_IDLE : uw.target;
        default:               upc_nxt = lpsr_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (go) begin
      unique case (uw.cnt)
        lpsr_pkg::CN_CLR:  cnt_nxt = '0;
        lpsr_pkg::CN_INC:  cnt_nxt = cnt_end ? '0 : cnt_r + 1'b1;
        default:           cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lpsr_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    ctl.ld_in    = accept;
    ctl.emit     = go ? uw.emit : lpsr_pkg::EM_NONE;
    ctl.last     = (uw.last == lpsr_pkg::LS_YES) || ((uw.last == lpsr_pkg::LS_CNT) && cnt_end);
    ctl.addr_sel = uw.addr_sel;
    ctl.ram_wr   = go && uw.ram_wr;
    ctl.clr      = go && uw.clr;
    ctl.cnt      = cnt_r;
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (upc_r == lpsr_pkg::ST_DECODE))
    else $error("accepted word not followed by decode");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("grid counter out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ($stable(upc_r) && $stable(cnt_r)))
    else $error("sequencer advanced while output stalled");

endmodule

`default_nettype wire

// ----- rtl/lpsr_dpath.sv -----
// ----------------------------------------------------------------------------
// lpsr_dpath
// Datapath: command latch, pixel map, shadow RAM and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsr_dpath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lpsr_pkg::ctl_t ctl,
  input  wire logic [2:0]     in_op,
  input  wire logic [4:0]     in_x,
  input  wire logic [2:0]     in_y,
  input  wire logic [7:0]     in_level,
  input  wire logic           out_ready,
  output logic [2:0]          op,
  output logic                slot_free,
  output logic                out_valid,
  output logic                out_kind,
  output logic [1:0]          out_line_mask,
  output logic [7:0]          out_lead_byte,
  output logic [7:0]          out_follow_byte,
  output logic                out_pixel_ok,
  output logic                out_last
);

  logic [2:0]                   op_r;
  logic [4:0]                   x_r;
  logic [2:0]                   y_r;
  logic [7:0]                   lvl_r;
  lpsr_pkg::loc_t               loc;
  logic [lpsr_pkg::CNT_W-2:0]   fgrid;
  logic [lpsr_pkg::IDX_W-1:0]   fidx, rd_addr;
  logic [7:0]                   fgrid_b, flead, rdata_r, rdata_eff, wdata;
  logic                         rvld_r, wr_en;
  logic [7:0]                   mem [lpsr_pkg::ENTRIES];
  logic [lpsr_pkg::ENTRIES-1:0] vld_r;
  logic [2:0]                   bright;
  logic                         ov_r, ov_nxt;
  logic                         kind_r, ok_r, last_r;
  logic [1:0]                   mask_r;
  logic [7:0]                   lead_r, follow_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      op_r  <= in_op;
      x_r   <= in_x;
      y_r   <= in_y;
      lvl_r <= in_level;
    end
  end

  assign op  = op_r;
  assign loc = lpsr_pkg::locate(x_r, y_r);

  // flush order: line L then line R for each grid
  assign fgrid   = ctl.cnt[lpsr_pkg::CNT_W-1:1];
  assign fidx    = ctl.cnt[0] ? lpsr_pkg::IDX_W'(lpsr_pkg::GRID_COUNT) + lpsr_pkg::IDX_W'(fgrid)
                              : lpsr_pkg::IDX_W'(fgrid);
  assign fgrid_b = 8'(fgrid);
  assign flead   = lpsr_pkg::CMD_GRID | (fgrid_b & lpsr_pkg::GRID_MASK);

  assign rd_addr   = (ctl.addr_sel == lpsr_pkg::AS_CNT) ? fidx : loc.idx;
  assign rdata_eff = rvld_r ? rdata_r : 8'h00;
  assign wr_en     = ctl.ram_wr && loc.ok;
  assign wdata     = rdata_eff | (8'h01 << loc.bit_pos);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[loc.idx] <= wdata;
    end
    rdata_r <= mem[rd_addr];
    rvld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[loc.idx] <= 1'b1;
    end
  end

  assign bright = (lvl_r > 8'd7) ? 3'd7 : lvl_r[2:0];

  // output word register
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    ov_nxt = ov_r;
    if (ctl.emit != lpsr_pkg::EM_NONE) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit != lpsr_pkg::EM_NONE) begin
      last_r <= ctl.last;
      unique case (ctl.emit)
        lpsr_pkg::EM_STATUS: begin
          kind_r   <= 1'b1;
          mask_r   <= 2'd0;
          lead_r   <= 8'h00;
          follow_r <= 8'h00;
          ok_r     <= loc.ok;
        end
        lpsr_pkg::EM_FRAME: begin
          kind_r   <= 1'b0;
          mask_r   <= ctl.cnt[0] ? 2'd2 : 2'd1;
          lead_r   <= flead;
          follow_r <= rdata_eff;
          ok_r     <= 1'b0;
        end
        lpsr_pkg::EM_ON: begin
          kind_r   <= 1'b0;
          mask_r   <= 2'd3;
          lead_r   <= lpsr_pkg::CMD_DISPLAY;
          follow_r <= lpsr_pkg::CTRL_ON | {5'd0, bright};
          ok_r     <= 1'b0;
        end
        default: begin
          kind_r   <= 1'b0;
          mask_r   <= 2'd3;
          lead_r   <= lpsr_pkg::CMD_DISPLAY;
          follow_r <= lpsr_pkg::CTRL_OFF;
          ok_r     <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = kind_r;
  assign out_line_mask   = mask_r;
  assign out_lead_byte   = lead_r;
  assign out_follow_byte = follow_r;
  assign out_pixel_ok    = ok_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// ----- rtl/led_panel_shadow_ram_controller.sv -----
// ----------------------------------------------------------------------------
// led_panel_shadow_ram_controller
// Two-line LED driver controller with a 2 x 24 byte shadow RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command word per handshake (set pixel, clear, flush, on, off).
//   out_* : result words; tuser is the kind (frame or pixel status), tlast
//           marks the final word of a command. Clear gives no word.
//   Commands are taken one at a time; in_tready is high while the
//   microcode sequencer waits in its idle step.
//   Set pixel: accept, decode, RAM read, then RAM write and status. Clear
//   and off: accept, decode, then the clear or the off word. Flush: accept,
//   decode, counter clear, then the frames; on emits its word first. Flush
//   pace is set by the registered RAM read port, one read step and one emit step per frame.
//   Result words pass through a single output register; when out_tready is
//   low the sequencer holds its emit step until the register is taken.
//   Reset (rst_n low, synchronous) returns to idle, drops out_tvalid and
//   clears the RAM valid bits, so the shadow RAM reads all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module led_panel_shadow_ram_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // operation[2:0], pixel_x[7:3], pixel_y[10:8],
                                       // level[18:11], zero[23:19]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // line_mask[1:0], lead_byte[9:2], follow_byte[17:10],
                                       // pixel_ok[18], zero[23:19]
  output logic             out_tuser,  // kind
  output logic             out_tlast
);

  lpsr_pkg::ctl_t ctl;
  logic [2:0]     op;
  logic           slot_free;
  logic           o_ok;
  logic [1:0]     o_mask;
  logic [7:0]     o_lead, o_follow;

  lpsr_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .op        (op),
    .slot_free (slot_free),
    .in_ready  (in_tready),
    .ctl       (ctl)
  );

  lpsr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_op           (in_tdata[2:0]),
    .in_x            (in_tdata[7:3]),
    .in_y            (in_tdata[10:8]),
    .in_level        (in_tdata[18:11]),
    .out_ready       (out_tready),
    .op              (op),
    .slot_free       (slot_free),
    .out_valid       (out_tvalid),
    .out_kind        (out_tuser),
    .out_line_mask   (o_mask),
    .out_lead_byte   (o_lead),
    .out_follow_byte (o_follow),
    .out_pixel_ok    (o_ok),
    .out_last        (out_tlast)
  );

  assign out_tdata = {5'd0, o_ok, o_follow, o_lead, o_mask};

endmodule

`default_nettype wire

// ----- verif/led_panel_shadow_ram_controller_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_panel_shadow_ram_controller_test
// Self-checking bench for the LED panel shadow RAM controller. A directed
// command table covers the map corners, the split and mirrored columns,
// rejected coordinates, unused opcodes, brightness saturation and clear.
// Random commands then run with random gaps on both streams and one long
// output hold-off. Every output word is compared with the next word from a
// local model of the shadow RAM and the brightness register.
// ----------------------------------------------------------------------------

module led_panel_shadow_ram_controller_test;

  localparam logic [2:0] OP_SET       = lpsr_pkg::OP_SET;
  localparam logic [2:0] OP_CLEAR     = lpsr_pkg::OP_CLEAR;
  localparam logic [2:0] OP_FLUSH     = lpsr_pkg::OP_FLUSH;
  localparam logic [2:0] OP_ON        = lpsr_pkg::OP_ON;
  localparam logic [2:0] OP_OFF       = lpsr_pkg::OP_OFF;
  localparam int         GRID_COUNT   = lpsr_pkg::GRID_COUNT;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic       KIND_FRAME   = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;
  localparam logic [1:0] LINE_NONE    = 2'd0;
  localparam logic [1:0] LINE_L       = 2'd1;
  localparam logic [1:0] LINE_R       = 2'd2;
  localparam logic [1:0] LINE_BOTH    = 2'd3;
  localparam logic [7:0] BUS_DISPLAY  = 8'h48;
  localparam logic [7:0] BUS_ON       = 8'h88;
  localparam logic [7:0] BUS_OFF      = 8'h80;
  localparam logic [7:0] BUS_GRID     = 8'hC0;
  localparam logic [7:0] NO_CELL      = 8'hFF;
  localparam int         EDGE_COL     = 27;
  localparam int         MAP_COLS     = 17;
  localparam int         MAX_LEVEL    = 7;

  localparam int RANDOM_ITEMS = 185;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic       kind;
    logic [1:0] mask;
    logic [7:0] lead;
    logic [7:0] follow;
    logic       ok;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] x;
    logic [2:0] y;
    logic [7:0] level;
    logic       fixed;
    word_t      want;
  } cmd_row_t;

  localparam word_t STATUS_OK  = '{KIND_STATUS, LINE_NONE, 8'h00, 8'h00, 1'b1, 1'b1};
  localparam word_t STATUS_BAD = '{KIND_STATUS, LINE_NONE, 8'h00, 8'h00, 1'b0, 1'b1};
  localparam word_t OFF_FRAME  = '{KIND_FRAME, LINE_BOTH, BUS_DISPLAY, BUS_OFF, 1'b0, 1'b1};
  localparam word_t NO_WORD    = '0;

  localparam int SCRIPT_LEN = 25;
  localparam cmd_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_FLUSH,     5'd0,  3'd0, 8'd0,   1'b0, NO_WORD},
    '{OP_OFF,       5'd0,  3'd0, 8'd0,   1'b1, OFF_FRAME},
    '{OP_SET,       5'd0,  3'd0, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd27, 3'd0, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd27, 3'd3, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd27, 3'd4, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd27, 3'd6, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd17, 3'd0, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd26, 3'd6, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd16, 3'd6, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd28, 3'd0, 8'd0,   1'b1, STATUS_BAD},
    '{OP_SET,       5'd31, 3'd7, 8'd255, 1'b1, STATUS_BAD},
    '{OP_SET,       5'd0,  3'd7, 8'd0,   1'b1, STATUS_BAD},
    '{OP_UNUSED_LO, 5'd31, 3'd7, 8'd255, 1'b0, NO_WORD},
    '{OP_UNUSED_HI, 5'd0,  3'd0, 8'd0,   1'b0, NO_WORD},
    '{OP_ON,        5'd0,  3'd0, 8'd0,   1'b0, NO_WORD},
    '{OP_ON,        5'd0,  3'd0, 8'd8,   1'b0, NO_WORD},
    '{OP_ON,        5'd0,  3'd0, 8'd255, 1'b0, NO_WORD},
    '{OP_ON,        5'd0,  3'd0, 8'd7,   1'b0, NO_WORD},
    '{OP_FLUSH,     5'd31, 3'd7, 8'd255, 1'b0, NO_WORD},
    '{OP_CLEAR,     5'd0,  3'd0, 8'd0,   1'b0, NO_WORD},
    '{OP_FLUSH,     5'd0,  3'd0, 8'd0,   1'b0, NO_WORD},
    '{OP_SET,       5'd13, 3'd5, 8'd0,   1'b1, STATUS_OK},
    '{OP_SET,       5'd13, 3'd5, 8'd0,   1'b1, STATUS_OK},
    '{OP_OFF,       5'd31, 3'd7, 8'd255, 1'b1, OFF_FRAME}
  };

  localparam logic [7:0] PIXEL_MAP [7][MAP_COLS] = '{
    '{8'hB6,8'h6B,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,8'h67,8'h68,8'h69,8'h6A,
      8'h76,8'h86,8'h96,8'hA7,8'hA5},
    '{8'hB5,8'h5B,8'h50,8'h51,8'h52,8'h53,8'h54,8'h56,8'h57,8'h58,8'h59,8'h5A,
      8'h75,8'h85,8'h95,8'h97,8'hA6},
    '{8'hB4,8'h4B,8'h40,8'h41,8'h42,8'h43,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,
      8'h74,8'h84,8'h94,8'hA9,8'hA8},
    '{8'hB3,8'h3B,8'h30,8'h31,8'h32,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3A,
      8'h73,8'h83,8'h93,8'h9A,8'h98},
    '{8'hB2,8'h2B,8'h20,8'h21,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,
      8'h72,8'h82,8'h92,8'h7A,8'h8A},
    '{8'hB1,8'h1B,8'h10,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,
      8'h71,8'h81,8'h91,8'h89,8'h87},
    '{8'hB0,8'h0B,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0A,
      8'h70,8'h80,8'h90,8'h79,8'h78}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [7:0] shadow_bytes [2*GRID_COUNT];
  logic [2:0] bright;
  word_t      pending_words [$];
  int         errors;
  int         words_taken;

  led_panel_shadow_ram_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic map_pixel(input logic [4:0] x, input logic [2:0] y,
                                     output int idx, output logic [2:0] bp);
    logic [7:0] map_byte;
    int         grid;
    logic       right;
    idx = 0;
    bp  = '0;
    if (x > EDGE_COL || y > 3'd6) return 1'b0;
    if (x == EDGE_COL) begin
      right = 1'b1;
      grid  = (y >= 3'd4) ? 15 : 14;
      bp    = 3'd6 - y;
    end else begin
      right    = (x >= MAP_COLS);
      map_byte = right ? PIXEL_MAP[y][28 - x] : PIXEL_MAP[y][x];
      if (map_byte == NO_CELL) return 1'b0;
      grid = int'(map_byte[7:3]);
      bp   = map_byte[2:0];
    end
    if (grid >= GRID_COUNT) return 1'b0;
    idx = right ? GRID_COUNT + grid : grid;
    return 1'b1;
  endfunction

  task automatic queue_flush();
    logic [7:0] lead;
    for (int g = 0; g < GRID_COUNT; g++) begin
      lead = BUS_GRID | (8'(g) & 8'h1F);
      pending_words.push_back('{KIND_FRAME, LINE_L, lead, shadow_bytes[g], 1'b0, 1'b0});
      pending_words.push_back('{KIND_FRAME, LINE_R, lead, shadow_bytes[GRID_COUNT + g],
                                1'b0, 1'b0});
    end
  endtask

  task automatic predict_command(input logic [2:0] op, input logic [4:0] x,
                                 input logic [2:0] y, input logic [7:0] level);
    int         idx;
    logic [2:0] bp;
    logic       ok;
    int         first;
    first = pending_words.size();
    case (op)
      OP_SET: begin
        ok = map_pixel(x, y, idx, bp);
        if (ok) shadow_bytes[idx][bp] = 1'b1;
        pending_words.push_back('{KIND_STATUS, LINE_NONE, 8'h00, 8'h00, ok, 1'b0});
      end
      OP_CLEAR: begin
        foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      end
      OP_FLUSH: queue_flush();
      OP_ON: begin
        bright = (level > MAX_LEVEL) ? 3'(MAX_LEVEL) : level[2:0];
        pending_words.push_back('{KIND_FRAME, LINE_BOTH, BUS_DISPLAY, BUS_ON | {5'd0, bright},
                                  1'b0, 1'b0});
        queue_flush();
      end
      OP_OFF: begin
        pending_words.push_back('{KIND_FRAME, LINE_BOTH, BUS_DISPLAY, BUS_OFF, 1'b0, 1'b0});
      end
      default: ;
    endcase
    if (pending_words.size() > first) pending_words[$].last = 1'b1;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // command stream
  initial begin
    cmd_row_t row;
    int       gap;
    int       sel;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    errors = 0;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
    bright = 3'(MAX_LEVEL);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int n = 0; n < SCRIPT_LEN + RANDOM_ITEMS; n++) begin
      if (n < SCRIPT_LEN) begin
        row = SCRIPT[n];
      end else begin
        sel       = $urandom_range(99);
        row       = '0;
        row.x     = ($urandom_range(5) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(27));
        row.y     = ($urandom_range(5) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(6));
        row.level = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(MAX_LEVEL));
        if (sel < 65)      row.op = OP_SET;
        else if (sel < 75) row.op = OP_FLUSH;
        else if (sel < 83) row.op = OP_ON;
        else if (sel < 89) row.op = OP_OFF;
        else if (sel < 94) row.op = OP_CLEAR;
        else               row.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      gap = ((n % 40) < 8) ? 0 : $urandom_range(3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {5'b0, row.level, row.y, row.x, row.op};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      predict_command(row.op, row.x, row.y, row.level);
      if (row.fixed) begin
        void'(pending_words.pop_back());
        pending_words.push_back(row.want);
      end
    end
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** led_panel_shadow_ram_controller: PASSED **");
    end else begin
      $display("** led_panel_shadow_ram_controller: FAILED **");
    end
    $finish;
  end

  // result stream
  initial begin
    word_t got;
    word_t want;
    int    stall;
    out_tready <= 1'b0;
    words_taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (words_taken == HOLD_AT) stall = HOLD_CYCLES;
      else if ((words_taken % 128) < 24) stall = 0;
      else stall = $urandom_range(3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = '{out_tuser, out_tdata[1:0], out_tdata[9:2], out_tdata[17:10], out_tdata[18],
              out_tlast};
      words_taken++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, got);
      end else begin
        want = pending_words.pop_front();
        check_field("kind", int'(want.kind), int'(got.kind));
        check_field("line_mask", int'(want.mask), int'(got.mask));
        check_field("lead_byte", int'(want.lead), int'(got.lead));
        check_field("follow_byte", int'(want.follow), int'(got.follow));
        check_field("pixel_ok", int'(want.ok), int'(got.ok));
        check_field("last", int'(want.last), int'(got.last));
      end
    end
  end

  // stall watchdog
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("** led_panel_shadow_ram_controller: FAILED **");
        $finish;
      end
    end
  end

endmodule
